// File: rtl/sfr_pkg.sv
// Package for the stream find-and-replace block.
// Holds the channel words, the register set and the control group types.
// Depends on nothing.
package sfr_pkg;

  // APB register map: one 64-bit register every 8 bytes
  localparam int CfgAddrW = 5;
  localparam int CfgDataW = 64;

  localparam logic [1:0] RegTargetLen   = 2'd0;
  localparam logic [1:0] RegTargetBytes = 2'd1;
  localparam logic [1:0] RegReplaceLen  = 2'd2;
  localparam logic [1:0] RegReplaceBytes = 2'd3;

  // Input word: one source byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  // Output word: one rewritten byte or a bare end marker
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
  } out_word_t;

  // Register contents as seen by the datapath
  typedef struct packed {
    logic [3:0]  target_len;
    logic [63:0] target_bytes;
    logic [3:0]  replace_len;
    logic [63:0] replace_bytes;
  } cfg_t;

  // Burst load control from the window logic to the output buffer
  typedef struct packed {
    logic load;
    logic last;
    logic mark;
  } ctl_t;

endpackage

// File: rtl/sfr_regs.sv
// APB register file for the stream find-and-replace block.
// Holds target and replacement registers; flags writes to the target length.
// Depends on sfr_pkg.
module sfr_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfr_pkg::CfgAddrW-1:0]  paddr,
  input  logic [sfr_pkg::CfgDataW-1:0]  pwdata,
  output logic [sfr_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output sfr_pkg::cfg_t                 cfg_o,
  output logic                          tlen_wr_o
);

  logic [3:0]  tlen_q;
  logic [63:0] tbytes_q;
  logic [3:0]  rlen_q;
  logic [63:0] rbytes_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlen_q   <= 4'd1;
      tbytes_q <= '0;
      rlen_q   <= '0;
      rbytes_q <= '0;
    end else if (wr) begin
      case (paddr[4:3])
        sfr_pkg::RegTargetLen:    tlen_q   <= pwdata[3:0];
        sfr_pkg::RegTargetBytes:  tbytes_q <= pwdata;
        sfr_pkg::RegReplaceLen:   rlen_q   <= pwdata[3:0];
        sfr_pkg::RegReplaceBytes: rbytes_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[4:3])
      sfr_pkg::RegTargetLen:    prdata = {60'd0, tlen_q};
      sfr_pkg::RegTargetBytes:  prdata = tbytes_q;
      sfr_pkg::RegReplaceLen:   prdata = {60'd0, rlen_q};
      sfr_pkg::RegReplaceBytes: prdata = rbytes_q;
      default:                  prdata = '0;
    endcase
  end

  // A new target length empties the window
  assign tlen_wr_o = wr && (paddr[4:3] == sfr_pkg::RegTargetLen);

  assign cfg_o.target_len    = tlen_q;
  assign cfg_o.target_bytes  = tbytes_q;
  assign cfg_o.replace_len   = rlen_q;
  assign cfg_o.replace_bytes = rbytes_q;

endmodule

// File: rtl/sfr_window.sv
// Match window for the stream find-and-replace block.
// Appends each accepted byte, compares against the target and builds the burst.
// Depends on sfr_pkg.
module sfr_window #(
  parameter int MAX_TARGET  = 8,
  parameter int MAX_REPLACE = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfr_pkg::cfg_t     cfg_i,
  input  logic              tlen_wr_i,
  input  logic              accept_i,
  input  sfr_pkg::in_word_t in_word_i,
  output sfr_pkg::ctl_t     ctl_o,
  output logic [7:0]        bytes_o [(((MAX_TARGET < 8) ? MAX_TARGET : 8) >
                                      ((MAX_REPLACE < 8) ? MAX_REPLACE : 8)) ?
                                     ((MAX_TARGET < 8) ? MAX_TARGET : 8) :
                                     ((MAX_REPLACE < 8) ? MAX_REPLACE : 8)],
  output logic [$clog2(((((MAX_TARGET < 8) ? MAX_TARGET : 8) >
                         ((MAX_REPLACE < 8) ? MAX_REPLACE : 8)) ?
                        ((MAX_TARGET < 8) ? MAX_TARGET : 8) :
                        ((MAX_REPLACE < 8) ? MAX_REPLACE : 8)) + 1)-1:0] cnt_o
);

  localparam int TCAP = (MAX_TARGET < 8) ? MAX_TARGET : 8;
  localparam int RCAP = (MAX_REPLACE < 8) ? MAX_REPLACE : 8;
  localparam int BUF  = (TCAP > RCAP) ? TCAP : RCAP;
  localparam int CW   = $clog2(TCAP + 1);
  localparam int RW   = $clog2(RCAP + 1);
  localparam int BW   = $clog2(BUF + 1);

  logic [7:0]    win_q [TCAP];
  logic [7:0]    win_d [TCAP];
  logic [7:0]    win_a [BUF];
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] tl, cnt0, cnt1;
  logic [RW-1:0] rl;
  logic          full, mism, match;
  logic [BW-1:0] nres;

  // Clamp the configured lengths
  always_comb begin
    if (cfg_i.target_len == 4'd0) begin
      tl = CW'(1);
    end else if (cfg_i.target_len > 4'(TCAP)) begin
      tl = CW'(TCAP);
    end else begin
      tl = CW'(cfg_i.target_len);
    end
    if (cfg_i.replace_len > 4'(RCAP)) begin
      rl = RW'(RCAP);
    end else begin
      rl = RW'(cfg_i.replace_len);
    end
  end

  // Append the new byte and compare the full window
  always_comb begin
    cnt0 = (cnt_q >= tl) ? '0 : cnt_q;
    cnt1 = cnt0 + CW'(1);
    full = (cnt1 == tl);
    for (int i = 0; i < BUF; i++) begin
      win_a[i] = '0;
    end
    for (int i = 0; i < TCAP; i++) begin
      win_a[i] = (CW'(i) == cnt0) ? in_word_i.in_byte : win_q[i];
    end
    mism = 1'b0;
    for (int i = 0; i < TCAP; i++) begin
      if ((CW'(i) < tl) && (win_a[i] != cfg_i.target_bytes[8*i +: 8])) begin
        mism = 1'b1;
      end
    end
    match = full && !mism;
  end

  // Build the burst: replacement, oldest byte, or the whole flushed window
  always_comb begin
    if (match) begin
      nres = BW'(rl);
    end else if (in_word_i.in_last) begin
      nres = BW'(cnt1);
    end else if (full) begin
      nres = BW'(1);
    end else begin
      nres = '0;
    end
    for (int i = 0; i < BUF; i++) begin
      bytes_o[i] = match ? cfg_i.replace_bytes[8*i +: 8] : win_a[i];
    end
    ctl_o.load = accept_i;
    ctl_o.last = in_word_i.in_last;
    ctl_o.mark = 1'b0;
    cnt_o      = nres;
    // Nothing to send at end of string: one bare end marker
    if (in_word_i.in_last && (nres == '0)) begin
      ctl_o.mark = 1'b1;
      cnt_o      = BW'(1);
      bytes_o[0] = '0;
    end
  end

  // Next window: empty after a match or a flush, drop the oldest byte when full
  always_comb begin
    for (int i = 0; i < TCAP; i++) begin
      win_d[i] = win_a[i];
    end
    if (match || in_word_i.in_last) begin
      cnt_d = '0;
    end else if (full) begin
      for (int i = 0; i < TCAP - 1; i++) begin
        win_d[i] = win_a[i+1];
      end
      cnt_d = tl - CW'(1);
    end else begin
      cnt_d = cnt1;
    end
  end

  // Hold the window fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (tlen_wr_i) begin
      cnt_q <= '0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
    end
  end

  // Window bytes
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q <= win_d;
    end
  end

endmodule

// File: rtl/sfr_outbuf.sv
// Burst output buffer for the stream find-and-replace block.
// Loads up to one burst of result bytes; sends one word per unstalled cycle.
// Depends on sfr_pkg.
module sfr_outbuf #(
  parameter int BUF = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfr_pkg::ctl_t      ctl_i,
  input  logic [7:0]         bytes_i [BUF],
  input  logic [$clog2(BUF+1)-1:0] cnt_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sfr_pkg::out_word_t out_word_o
);

  localparam int BW = $clog2(BUF + 1);

  logic [7:0]    buf_q [BUF];
  logic [BW-1:0] left_q;
  logic          last_q, mark_q;
  logic          take;

  assign out_valid_o = (left_q != '0);
  assign take        = out_valid_o && !out_stall_i;
  assign can_load_o  = (left_q == '0) || ((left_q == BW'(1)) && take);

  assign out_word_o.out_byte   = buf_q[0];
  assign out_word_o.byte_valid = !mark_q;
  assign out_word_o.out_last   = last_q && (left_q == BW'(1));

  // Load a burst or advance by one word
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      buf_q <= bytes_i;
    end else if (take) begin
      for (int i = 0; i < BUF - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

  // Count the words left in the burst
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      last_q <= 1'b0;
      mark_q <= 1'b0;
    end else if (ctl_i.load) begin
      left_q <= cnt_i;
      last_q <= ctl_i.last;
      mark_q <= ctl_i.mark;
    end else if (take) begin
      left_q <= left_q - BW'(1);
    end
  end

endmodule

// File: rtl/stream_find_and_replace.sv
// Stream find-and-replace: top level.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) carries one source byte
//   per word with a last flag. Output channel (out_valid_o / out_stall_i /
//   out_word_o) carries rewritten bytes; byte_valid is 0 only on a bare end
//   marker sent when a string leaves no bytes. out_last marks the final word.
//   The APB port (64-bit data, registers at 8-byte steps) sets target length,
//   target bytes, replacement length and replacement bytes; write it only
//   while no string is in flight. Writing the target length empties the window.
// The first result word of an accepted byte shows in the cycle after it.
// Throughput: one byte per cycle while out_stall_i is low and each byte yields
//   at most one word. A byte that yields more words (a replacement burst or an
//   end-of-string flush, up to 8) holds the input while the output buffer
//   drains one word per unstalled cycle; a byte that yields no word does not.
// Stall: out_stall_i holds the current word; the input stalls once the
//   buffer cannot take the next burst.
// Reset: the window empties, registers return to target length 1 and zero
//   elsewhere, and no word is pending.
// Depends on sfr_pkg, sfr_regs, sfr_window and sfr_outbuf.
module stream_find_and_replace #(
  parameter int MAX_TARGET  = 8,
  parameter int MAX_REPLACE = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sfr_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sfr_pkg::out_word_t            out_word_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfr_pkg::CfgAddrW-1:0]  paddr,
  input  logic [sfr_pkg::CfgDataW-1:0]  pwdata,
  output logic [sfr_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);

  localparam int TCAP = (MAX_TARGET < 8) ? MAX_TARGET : 8;
  localparam int RCAP = (MAX_REPLACE < 8) ? MAX_REPLACE : 8;
  localparam int BUF  = (TCAP > RCAP) ? TCAP : RCAP;
  localparam int BW   = $clog2(BUF + 1);

  sfr_pkg::cfg_t cfg;
  sfr_pkg::ctl_t ctl;
  logic          tlen_wr;
  logic          can_load;
  logic          accept;
  logic [7:0]    burst_bytes [BUF];
  logic [BW-1:0] burst_cnt;

  // Take a byte whenever the output buffer can hold its burst
  assign accept     = in_valid_i && can_load;
  assign in_stall_o = !can_load;

  sfr_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .tlen_wr_o (tlen_wr)
  );

  sfr_window #(
    .MAX_TARGET  (MAX_TARGET),
    .MAX_REPLACE (MAX_REPLACE)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .tlen_wr_i (tlen_wr),
    .accept_i  (accept),
    .in_word_i (in_word_i),
    .ctl_o     (ctl),
    .bytes_o   (burst_bytes),
    .cnt_o     (burst_cnt)
  );

  sfr_outbuf #(
    .BUF (BUF)
  ) u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .bytes_i     (burst_bytes),
    .cnt_i       (burst_cnt),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
